/* hdl/palette_index_to_rgba_defines.svh */
// assertion macros for the palette index to rgba converter
// expects clk and arst_n in the scope of each use
`ifndef PALETTE_INDEX_TO_RGBA_DEFINES_SVH
`define PALETTE_INDEX_TO_RGBA_DEFINES_SVH

`ifndef SYNTHESIS
`define PIT_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("palette_index_to_rgba check failed");
`define PIT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("palette_index_to_rgba check failed");
`else
`define PIT_ASSERT_IMPL(label, ante, cons)
`define PIT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* hdl/pit_pkg.sv */
// shared types and constants of the palette index to rgba converter
// no dependencies
package pit_pkg;

	localparam int unsigned PIT_IDX_W = 8;
	localparam int unsigned PIT_DEPTH = 1 << PIT_IDX_W;

	localparam logic [1:0] CMD_CONVERT       = 2'd0;
	localparam logic [1:0] CMD_WRITE_PALETTE = 2'd1;
	localparam logic [1:0] CMD_WRITE_GAMMA   = 2'd2;

	localparam logic [1:0] REG_TRANSPARENT_INDEX  = 2'd0;
	localparam logic [1:0] REG_PREMULTIPLY_ENABLE = 2'd1;
	localparam logic [1:0] REG_GAMMA_ENABLE       = 2'd2;
	localparam logic [1:0] REG_PALETTE_VALID      = 2'd3;

	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
	localparam logic [7:0] ALPHA_CLEAR  = 8'd0;
	localparam logic [7:0] TRANSPARENT_RESET = 8'd255;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef struct packed {
		logic                 en;
		logic [PIT_IDX_W-1:0] addr;
		logic [7:0]           data;
	} gamma_wr_t;

endpackage

/* hdl/pit_gamma_lut.sv */
// gamma lookup: three identical banks, one per colour channel
// depends on pit_pkg
module pit_gamma_lut import pit_pkg::*; (
	input  logic      clk,
	input  gamma_wr_t wr,
	input  logic      rd_en,
	input  rgb_t      rd_addr,
	output rgb_t      rd_data
);

	logic [7:0] bank_red   [PIT_DEPTH];
	logic [7:0] bank_green [PIT_DEPTH];
	logic [7:0] bank_blue  [PIT_DEPTH];

	// every write goes to all banks so each channel gets its own read port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			bank_red[wr.addr]   <= wr.data;
			bank_green[wr.addr] <= wr.data;
			bank_blue[wr.addr]  <= wr.data;
		end
		if (rd_en) begin
			rd_data.red   <= bank_red[rd_addr.red];
			rd_data.green <= bank_green[rd_addr.green];
			rd_data.blue  <= bank_blue[rd_addr.blue];
		end
	end

endmodule

/* hdl/palette_index_to_rgba.sv */
// top level of the palette index to rgba converter
// depends on pit_pkg, pit_gamma_lut and palette_index_to_rgba_defines.svh
//
// Usage:
// s_* carries one command per transfer: s_tuser selects convert, palette write
// or gamma write, s_tdata carries the index and the entry bytes.
// A convert yields one rgba pixel on m_*; write commands yield nothing.
// cfg_* writes the four control registers; cfg_ready is always high. Change
// registers only while no pixel is in flight; the block does not enforce it.
// A convert passes stage s1 and then stage s2 before it shows on m_tvalid.
// Throughput: one command per cycle unless held; the path is the palette
// memory read then the gamma table read, each one registered memory port.
// When m_tready is low with a pixel waiting, the whole pipe holds and s_tready
// drops; it rises again in the cycle the waiting pixel is taken.
// Reset clears the pipe valids and the control registers (transparent index
// 255, everything else off). The palette and gamma memories are not cleared:
// load them before converting with them.
`include "palette_index_to_rgba_defines.svh"

module palette_index_to_rgba import pit_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// index[7:0], entry_red[15:8], entry_green[23:16], entry_blue[31:24],
	// gamma_value[39:32]
	input  logic [39:0] s_tdata,
	// command[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
	output logic [31:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic [7:0] transparent_index_q;
	logic       premultiply_enable_q;
	logic       gamma_enable_q;
	logic       palette_valid_q;

	logic                 adv;
	logic                 accept;
	logic [1:0]           in_cmd;
	logic [PIT_IDX_W-1:0] in_idx;
	rgb_t                 in_entry;
	logic [7:0]           in_gamma;

	logic [23:0]          palette_mem [PIT_DEPTH];
	rgb_t                 pal_rd_s1;
	logic                 valid_s1;
	logic [PIT_IDX_W-1:0] idx_s1;
	rgb_t                 colour_s1;

	gamma_wr_t            gamma_wr;
	rgb_t                 gamma_rd_s2;
	logic                 valid_s2;
	rgb_t                 colour_s2;
	logic                 clear_s2;
	rgb_t                 colour_out;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transparent_index_q  <= TRANSPARENT_RESET;
			premultiply_enable_q <= 1'b0;
			gamma_enable_q       <= 1'b0;
			palette_valid_q      <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TRANSPARENT_INDEX:  transparent_index_q  <= cfg_data;
				REG_PREMULTIPLY_ENABLE: premultiply_enable_q <= cfg_data[0];
				REG_GAMMA_ENABLE:       gamma_enable_q       <= cfg_data[0];
				REG_PALETTE_VALID:      palette_valid_q      <= cfg_data[0];
				default:                palette_valid_q      <= palette_valid_q;
			endcase
		end
	end

	// input fields
	assign in_cmd         = s_tuser;
	assign in_idx         = s_tdata[7:0];
	assign in_entry.red   = s_tdata[15:8];
	assign in_entry.green = s_tdata[23:16];
	assign in_entry.blue  = s_tdata[31:24];
	assign in_gamma       = s_tdata[39:32];

	// the whole pipe moves unless a finished pixel is stuck at the output
	assign adv      = !valid_s2 || m_tready;
	assign s_tready = adv;
	assign accept   = s_tvalid && adv;

	// palette memory: writes land at the accept edge, so a later convert always
	// sees them; only one command enters per edge
	always_ff @(posedge clk) begin
		if (accept && in_cmd == CMD_WRITE_PALETTE) begin
			palette_mem[in_idx] <= in_entry;
		end
		if (adv) begin
			pal_rd_s1 <= palette_mem[in_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept && in_cmd == CMD_CONVERT;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1 <= in_idx;
		end
	end

	always_comb begin
		if (palette_valid_q) begin
			colour_s1 = pal_rd_s1;
		end else begin
			colour_s1 = '{red: idx_s1, green: idx_s1, blue: idx_s1};
		end
	end

	// gamma table: read is read-first, so a write accepted at the same edge
	// belongs to a later command and correctly stays unseen
	assign gamma_wr.en   = accept && in_cmd == CMD_WRITE_GAMMA;
	assign gamma_wr.addr = in_idx;
	assign gamma_wr.data = in_gamma;

	pit_gamma_lut u_gamma (
		.clk     (clk),
		.wr      (gamma_wr),
		.rd_en   (adv),
		.rd_addr (colour_s1),
		.rd_data (gamma_rd_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			colour_s2 <= colour_s1;
			clear_s2  <= idx_s1 == transparent_index_q;
		end
	end

	// gamma, then premultiply
	always_comb begin
		colour_out = gamma_enable_q ? gamma_rd_s2 : colour_s2;
		if (premultiply_enable_q && clear_s2) begin
			colour_out = '0;
		end
	end

	assign m_tvalid       = valid_s2;
	assign m_tdata[7:0]   = colour_out.red;
	assign m_tdata[15:8]  = colour_out.green;
	assign m_tdata[23:16] = colour_out.blue;
	assign m_tdata[31:24] = clear_s2 ? ALPHA_CLEAR : ALPHA_OPAQUE;

	`PIT_ASSERT_NEXT(a_convert_enters, accept && in_cmd == CMD_CONVERT, valid_s1)
	`PIT_ASSERT_NEXT(a_write_no_pixel, adv && !(s_tvalid && in_cmd == CMD_CONVERT), !valid_s1)
	`PIT_ASSERT_NEXT(a_s1_holds, valid_s1 && !adv, valid_s1 && $stable(idx_s1))
	`PIT_ASSERT_IMPL(a_premult_zero, m_tvalid && premultiply_enable_q && clear_s2, m_tdata[23:0] == 24'd0)

endmodule
